// ----- rtl/core/odiso_pkg.sv -----
`timescale 1ns / 1ps

package odiso_pkg;

    // year store depth and derived widths
    localparam int YEAR_CHARS = 4;
    localparam int YEAR_LEN_W = $clog2(YEAR_CHARS + 1);
    localparam int YEAR_IDX_W = (YEAR_CHARS > 1) ? $clog2(YEAR_CHARS) : 1;

    // character codes
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DASH  = 8'h2d;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_TWO   = 8'h32;
    localparam logic [7:0] CH_THREE = 8'h33;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // month names, january first
    localparam logic [23:0] MONTH_NAMES [12] = '{
        "Jan", "Feb", "Mar", "Apr", "May", "Jun",
        "Jul", "Aug", "Sep", "Oct", "Nov", "Dec"
    };

    // one decoded line, handed from the tokenizer to the emitter
    typedef struct packed {
        logic [YEAR_CHARS-1:0][7:0] year_text;
        logic [YEAR_LEN_W-1:0]      year_len;
        logic [3:0]                 month;
        logic                       day_ok;
        logic [7:0]                 day_tens;
        logic [7:0]                 day_ones;
        logic                       bad;
    } odiso_line_t;

    // emitter phases
    typedef enum logic [2:0] {
        EM_IDLE,
        EM_YEAR,
        EM_DASH1,
        EM_MON_HI,
        EM_MON_LO,
        EM_DASH2,
        EM_DAY_HI,
        EM_DAY_LO
    } odiso_emit_state_t;

endpackage

// ----- rtl/core/odiso_tokenizer.sv -----
`timescale 1ns / 1ps

module odiso_tokenizer
    import odiso_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic [7:0]  in_char,
    input  logic        in_last,
    output logic        line_done,
    output odiso_line_t line
);

    logic [1:0]                  tok_reg, tok_next;
    logic [7:0]                  day_text_reg [4];
    logic [7:0]                  day_text_next [4];
    logic [2:0]                  day_len_reg, day_len_next;
    logic [7:0]                  mon_text_reg [3];
    logic [7:0]                  mon_text_next [3];
    logic [2:0]                  mon_len_reg, mon_len_next;
    logic [YEAR_CHARS-1:0][7:0]  year_text_reg, year_text_next;
    logic [YEAR_LEN_W-1:0]       year_len_reg, year_len_next;
    logic                        ovf_reg, ovf_next;

    // token state update for one character
    always_comb
    begin
        tok_next       = tok_reg;
        day_text_next  = day_text_reg;
        day_len_next   = day_len_reg;
        mon_text_next  = mon_text_reg;
        mon_len_next   = mon_len_reg;
        year_text_next = year_text_reg;
        year_len_next  = year_len_reg;
        ovf_next       = ovf_reg;
        if (in_char == CH_SPACE)
        begin
            if (tok_reg < 2'd2)
            begin
                tok_next = tok_reg + 2'd1;
            end
            year_len_next = '0;
            ovf_next      = 1'b0;
        end
        else
        begin
            if (tok_reg == 2'd0)
            begin
                if (day_len_reg < 3'd4)
                begin
                    day_text_next[day_len_reg[1:0]] = in_char;
                    day_len_next = day_len_reg + 3'd1;
                end
                else
                begin
                    day_len_next = 3'd5;
                end
            end
            else if (tok_reg == 2'd1)
            begin
                if (mon_len_reg < 3'd3)
                begin
                    mon_text_next[mon_len_reg[1:0]] = in_char;
                    mon_len_next = mon_len_reg + 3'd1;
                end
                else
                begin
                    mon_len_next = 3'd4;
                end
            end
            if (year_len_reg < YEAR_LEN_W'(YEAR_CHARS))
            begin
                year_text_next[year_len_reg[YEAR_IDX_W-1:0]] = in_char;
                year_len_next = year_len_reg + 1'b1;
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
    end

    // day decode: ordinal with matching suffix, 1 to 31
    logic [7:0] d_tens, d_ones, suf0, suf1, want0, want1;
    logic       d_digits_ok, teen;

    always_comb
    begin
        d_tens      = CH_ZERO;
        d_ones      = day_text_next[0];
        suf0        = day_text_next[1];
        suf1        = day_text_next[2];
        d_digits_ok = 1'b0;
        if (day_len_next == 3'd3)
        begin
            d_digits_ok = (day_text_next[0] >= CH_ONE) && (day_text_next[0] <= CH_NINE);
        end
        else if (day_len_next == 3'd4)
        begin
            d_tens = day_text_next[0];
            d_ones = day_text_next[1];
            suf0   = day_text_next[2];
            suf1   = day_text_next[3];
            d_digits_ok = (day_text_next[0] >= CH_ONE) && (day_text_next[0] <= CH_THREE)
                && (day_text_next[1] >= CH_ZERO) && (day_text_next[1] <= CH_NINE)
                && !((day_text_next[0] == CH_THREE) && (day_text_next[1] > CH_ONE));
        end
        teen = (d_tens == CH_ONE);
        if ((d_ones == CH_ONE) && !teen)
        begin
            want0 = "s";
            want1 = "t";
        end
        else if ((d_ones == CH_TWO) && !teen)
        begin
            want0 = "n";
            want1 = "d";
        end
        else if ((d_ones == CH_THREE) && !teen)
        begin
            want0 = "r";
            want1 = "d";
        end
        else
        begin
            want0 = "t";
            want1 = "h";
        end
    end

    // month decode: case-sensitive three-letter name
    logic [3:0] mon_num;

    always_comb
    begin
        mon_num = 4'd0;
        if ((tok_next == 2'd2) && (mon_len_next == 3'd3))
        begin
            for (int k = 0; k < 12; k++)
            begin
                if ({mon_text_next[0], mon_text_next[1], mon_text_next[2]} == MONTH_NAMES[k])
                begin
                    mon_num = 4'(k + 1);
                end
            end
        end
    end

    // decoded line as seen after this character
    always_comb
    begin
        line.year_text = year_text_next;
        line.year_len  = year_len_next;
        line.month     = mon_num;
        line.day_ok    = (tok_next != 2'd0) && d_digits_ok && (suf0 == want0)
                         && (suf1 == want1);
        line.day_tens  = d_tens;
        line.day_ones  = d_ones;
        line.bad       = !line.day_ok || (mon_num == 4'd0) || ovf_next;
    end

    assign line_done = accept && in_last;

    // control state, cleared after the final character of each line
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg      <= '0;
            day_len_reg  <= '0;
            mon_len_reg  <= '0;
            year_len_reg <= '0;
            ovf_reg      <= 1'b0;
        end
        else if (accept)
        begin
            if (in_last)
            begin
                tok_reg      <= '0;
                day_len_reg  <= '0;
                mon_len_reg  <= '0;
                year_len_reg <= '0;
                ovf_reg      <= 1'b0;
            end
            else
            begin
                tok_reg      <= tok_next;
                day_len_reg  <= day_len_next;
                mon_len_reg  <= mon_len_next;
                year_len_reg <= year_len_next;
                ovf_reg      <= ovf_next;
            end
        end
    end

    // token text, read only below the stored lengths
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            day_text_reg  <= day_text_next;
            mon_text_reg  <= mon_text_next;
            year_text_reg <= year_text_next;
        end
    end

endmodule

// ----- rtl/core/odiso_emitter.sv -----
`timescale 1ns / 1ps

module odiso_emitter
    import odiso_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  odiso_line_t line,
    output logic        busy,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_char,
    output logic        out_last,
    output logic        bad_field
);

    odiso_emit_state_t       state_reg, state_next;
    logic [YEAR_IDX_W-1:0]   ycnt_reg, ycnt_next;
    odiso_line_t             snap_reg;
    logic                    out_valid_reg;
    logic [7:0]              out_char_reg;
    logic                    out_last_reg;
    logic                    bad_reg;
    logic                    adv;
    logic                    year_end;
    logic [7:0]              emit_char;
    logic                    emit_last;

    assign adv  = !out_valid_reg || !out_stall;
    assign busy = (state_reg != EM_IDLE);
    assign year_end = ({1'b0, YEAR_LEN_W'(ycnt_reg)} + 1'b1) == {1'b0, snap_reg.year_len};

    // next phase
    always_comb
    begin
        state_next = state_reg;
        ycnt_next  = ycnt_reg;
        if (state_reg == EM_IDLE)
        begin
            if (load)
            begin
                state_next = (line.year_len != '0) ? EM_YEAR : EM_DASH1;
                ycnt_next  = '0;
            end
        end
        else if (adv)
        begin
            unique case (state_reg)
                EM_IDLE:   state_next = EM_IDLE;
                EM_YEAR:
                begin
                    ycnt_next = ycnt_reg + 1'b1;
                    if (year_end)
                    begin
                        state_next = EM_DASH1;
                    end
                end
                EM_DASH1:  state_next = (snap_reg.month != 4'd0) ? EM_MON_HI : EM_DASH2;
                EM_MON_HI: state_next = EM_MON_LO;
                EM_MON_LO: state_next = EM_DASH2;
                EM_DASH2:  state_next = snap_reg.day_ok ? EM_DAY_HI : EM_IDLE;
                EM_DAY_HI: state_next = EM_DAY_LO;
                EM_DAY_LO: state_next = EM_IDLE;
            endcase
        end
    end

    // character for the current phase
    always_comb
    begin
        emit_last = 1'b0;
        unique case (state_reg)
            EM_IDLE:   emit_char = CH_DASH;
            EM_YEAR:   emit_char = snap_reg.year_text[ycnt_reg];
            EM_DASH1:  emit_char = CH_DASH;
            EM_MON_HI: emit_char = (snap_reg.month >= 4'd10) ? CH_ONE : CH_ZERO;
            EM_MON_LO:
            begin
                if (snap_reg.month >= 4'd10)
                begin
                    emit_char = CH_ZERO + {4'd0, snap_reg.month - 4'd10};
                end
                else
                begin
                    emit_char = CH_ZERO + {4'd0, snap_reg.month};
                end
            end
            EM_DASH2:
            begin
                emit_char = CH_DASH;
                emit_last = !snap_reg.day_ok;
            end
            EM_DAY_HI: emit_char = snap_reg.day_tens;
            EM_DAY_LO:
            begin
                emit_char = snap_reg.day_ones;
                emit_last = 1'b1;
            end
        endcase
    end

    // phase and output control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= EM_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (adv)
            begin
                out_valid_reg <= busy;
            end
        end
    end

    // line snapshot, year position and output payload
    always_ff @(posedge clk)
    begin
        ycnt_reg <= ycnt_next;
        if (!busy && load)
        begin
            snap_reg <= line;
        end
        if (adv && busy)
        begin
            out_char_reg <= emit_char;
            out_last_reg <= emit_last;
            bad_reg      <= snap_reg.bad;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign out_last  = out_last_reg;
    assign bad_field = bad_reg;

endmodule

// ----- rtl/core/ordinal_date_to_iso_text_core.sv -----
// first result: the final transfer loads the emitter, whose first character is then registered
// throughput: one input character per cycle; a line's final character waits while the emitter
//   sends the previous line (year length and up to six characters, one a cycle unless stalled)
// reset: asynchronous, active low; clears the token state and the emitter, no output pending
`timescale 1ns / 1ps

module ordinal_date_to_iso_text_core
    import odiso_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_char,
    input  logic       in_last,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_char,
    output logic       out_last,
    output logic       bad_field
);

    odiso_line_t line;
    logic        line_done;
    logic        busy;
    logic        accept;

    // only the final character needs a free emitter
    assign in_stall = in_last && busy;
    assign accept   = in_valid && !in_stall;

    odiso_tokenizer u_tok (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .in_char   (in_char),
        .in_last   (in_last),
        .line_done (line_done),
        .line      (line)
    );

    odiso_emitter u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (line_done),
        .line      (line),
        .busy      (busy),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_char  (out_char),
        .out_last  (out_last),
        .bad_field (bad_field)
    );

endmodule

// ----- rtl/core/odiso_checker.sv -----
`timescale 1ns / 1ps

module odiso_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       in_last,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] out_char,
    input logic       out_last,
    input logic       bad_field
);

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_char) && $stable(out_last)
            && $stable(bad_field))
        else $error("stalled result changed");

    // a line-ending transfer is followed by a valid result
    a_line_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && in_last |=> ##1 out_valid)
        else $error("no result after line end");

    // a result burst has no gaps
    a_burst_gapless: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !out_last |=> out_valid)
        else $error("gap inside result burst");

    // characters inside a line are never held back
    a_mid_line_flow: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_last |-> !in_stall)
        else $error("mid-line character stalled");

endmodule

bind ordinal_date_to_iso_text_core odiso_checker u_odiso_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_last   (in_last),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_char  (out_char),
    .out_last  (out_last),
    .bad_field (bad_field)
);
